// File: hdl/hamvl_pkg.sv
// Shared constants, types and table builders for the variable-length Hamming encoder.
// No dependencies; imported by hamvl_pipe and the top level.
package hamvl_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int CW_W          = 63;
    localparam int LEN_W         = 6;
    localparam int CHK_W         = 3;
    localparam int MAX_CHK       = 6;
    localparam int CHUNK_W       = 16;
    localparam int NUM_CHUNKS    = (CW_W + CHUNK_W - 1) / CHUNK_W;
    localparam int ADDR_W        = 3;

    // register indexes
    localparam logic REG_DATA_LENGTH = 1'b0;

    localparam logic [LEN_W-1:0] DATA_LENGTH_RST = LEN_W'(8);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [CHK_W-1:0] chk;
    } t_fmt;

    typedef logic [LEN_W-1:0]         t_pos_tab [MAX_DATA_BITS];
    typedef logic [MAX_CHK-1:0][CW_W-1:0] t_grp_tab;

    // code bit index (0-based) of each data bit: the non-power-of-two positions in order
    function automatic t_pos_tab build_pos_tab();
        t_pos_tab tab;
        int       cnt;
        cnt = 0;
        for (int d = 0; d < MAX_DATA_BITS; d++) begin
            tab[d] = '0;
        end
        for (int j = 1; j <= CW_W; j++) begin
            if (((j & (j - 1)) != 0) && (cnt < MAX_DATA_BITS)) begin
                tab[cnt] = LEN_W'(j - 1);
                cnt      = cnt + 1;
            end
        end
        return tab;
    endfunction

    // parity group k: all positions whose index has bit k set
    function automatic t_grp_tab build_grp_tab();
        t_grp_tab tab;
        for (int k = 0; k < MAX_CHK; k++) begin
            for (int j = 1; j <= CW_W; j++) begin
                tab[k][j-1] = ((j >> k) & 1) != 0;
            end
        end
        return tab;
    endfunction

    localparam t_pos_tab DATA_POS = build_pos_tab();
    localparam t_grp_tab GRP_MASK = build_grp_tab();

    // clamp raw length to 1..MAX_DATA_BITS
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] n;
        n = raw;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_DATA_BITS)) begin
            n = LEN_W'(MAX_DATA_BITS);
        end
        return n;
    endfunction

    // smallest r with 2^r >= n + r + 1
    function automatic logic [CHK_W-1:0] calc_chk(input logic [LEN_W-1:0] n);
        logic [CHK_W-1:0] r;
        logic             found;
        r     = '0;
        found = 1'b0;
        for (int k = 0; k <= MAX_CHK; k++) begin
            if (!found && ((1 << k) >= (int'(n) + k + 1))) begin
                r     = CHK_W'(k);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [MAX_DATA_BITS-1:0] make_mask(input logic [LEN_W-1:0] n);
        logic [MAX_DATA_BITS-1:0] m;
        for (int i = 0; i < MAX_DATA_BITS; i++) begin
            m[i] = LEN_W'(i) < n;
        end
        return m;
    endfunction

endpackage

// File: hdl/hamming_encoder_variable_length_unit.sv
// Top level of the variable-length Hamming encoder: APB register and encode pipeline.
// Depends on hamvl_pkg and hamvl_pipe.
//
//  channel  direction  handshake              payload
//  command  in         i_start, o_busy        i_data_word[56:0]
//  result   out        o_done (one cycle)     o_codeword[62:0], o_code_length, o_check_bits
//  config   in/out     psel/penable/pwrite    paddr, pwdata, prdata (data_length at 0x0)
//
// One word per cycle; each result passes the registered stages s1, s2 and s3 in turn.
// o_busy is always low: nothing in the pipeline can hold a word back.
// The receiver cannot stall; every o_done pulse must be taken.
// Synchronous active-low reset clears the valid bits and sets data_length to 8.
module hamming_encoder_variable_length_unit
    import hamvl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [MAX_DATA_BITS-1:0] i_data_word,
    output logic                     o_done,
    output logic [CW_W-1:0]          o_codeword,
    output logic [LEN_W-1:0]         o_code_length,
    output logic [CHK_W-1:0]         o_check_bits,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [LEN_W-1:0]         r_data_length;
    logic [MAX_DATA_BITS-1:0] r_mask;
    t_fmt                     r_fmt;
    logic [LEN_W-1:0]         n_eff;
    logic                     cfg_wr;
    t_fmt                     pipe_fmt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_DATA_LENGTH);
    assign n_eff  = eff_length(pwdata[LEN_W-1:0]);

    // length-derived format is settled at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= DATA_LENGTH_RST;
            r_mask        <= make_mask(DATA_LENGTH_RST);
            r_fmt.len     <= DATA_LENGTH_RST + LEN_W'(calc_chk(DATA_LENGTH_RST));
            r_fmt.chk     <= calc_chk(DATA_LENGTH_RST);
        end else if (cfg_wr) begin
            r_data_length <= pwdata[LEN_W-1:0];
            r_mask        <= make_mask(n_eff);
            r_fmt.len     <= n_eff + LEN_W'(calc_chk(n_eff));
            r_fmt.chk     <= calc_chk(n_eff);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1] == REG_DATA_LENGTH) begin
            prdata = 32'(r_data_length);
        end
    end

    assign o_busy = 1'b0;

    hamvl_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start),
        .i_data_word (i_data_word),
        .i_mask      (r_mask),
        .i_fmt       (r_fmt),
        .o_done      (o_done),
        .o_codeword  (o_codeword),
        .o_fmt       (pipe_fmt)
    );

    assign o_code_length = pipe_fmt.len;
    assign o_check_bits  = pipe_fmt.chk;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 3))
        else $error("result without a start three cycles earlier");

    a_upper_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_codeword >> o_code_length) == '0))
        else $error("codeword bits set above code length");

    a_fmt_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_check_bits != '0) && (o_code_length > LEN_W'(o_check_bits)))
        else $error("check bit count inconsistent with code length");
`endif

endmodule

// File: hdl/hamvl_pipe.sv
// Three-stage encode pipeline: mask, scatter with partial parities, check-bit insert.
// Depends on hamvl_pkg.
module hamvl_pipe
    import hamvl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [MAX_DATA_BITS-1:0] i_data_word,
    input  logic [MAX_DATA_BITS-1:0] i_mask,
    input  t_fmt                     i_fmt,
    output logic                     o_done,
    output logic [CW_W-1:0]          o_codeword,
    output t_fmt                     o_fmt
);

    // stage 1
    logic                     r_s1_vld;
    logic [MAX_DATA_BITS-1:0] r_s1_data;
    t_fmt                     r_s1_fmt;

    // stage 2
    logic                                  r_s2_vld;
    logic [CW_W-1:0]                       r_s2_code;
    logic [MAX_CHK-1:0][NUM_CHUNKS-1:0]    r_s2_part;
    t_fmt                                  r_s2_fmt;
    logic [CW_W-1:0]                       n_s2_code;
    logic [MAX_CHK-1:0][NUM_CHUNKS-1:0]    n_s2_part;

    // stage 3
    logic            r_s3_vld;
    logic [CW_W-1:0] r_s3_code;
    t_fmt            r_s3_fmt;
    logic [CW_W-1:0] n_s3_code;

    logic [NUM_CHUNKS*CHUNK_W-1:0] s2_wide;
    logic [NUM_CHUNKS*CHUNK_W-1:0] s2_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_data <= i_data_word & i_mask;
        r_s1_fmt  <= i_fmt;
        r_s2_code <= n_s2_code;
        r_s2_part <= n_s2_part;
        r_s2_fmt  <= r_s1_fmt;
        r_s3_code <= n_s3_code;
        r_s3_fmt  <= r_s2_fmt;
    end

    // data bits land at fixed positions; masked bits are already zero
    always_comb begin
        n_s2_code = '0;
        for (int d = 0; d < MAX_DATA_BITS; d++) begin
            n_s2_code[DATA_POS[d]] = r_s1_data[d];
        end
    end

    assign s2_wide = (NUM_CHUNKS*CHUNK_W)'(n_s2_code);

    always_comb begin
        s2_grp    = '0;
        n_s2_part = '0;
        for (int k = 0; k < MAX_CHK; k++) begin
            s2_grp = s2_wide & (NUM_CHUNKS*CHUNK_W)'(GRP_MASK[k]);
            for (int c = 0; c < NUM_CHUNKS; c++) begin
                n_s2_part[k][c] = ^s2_grp[c*CHUNK_W +: CHUNK_W];
            end
        end
    end

    always_comb begin
        n_s3_code = r_s2_code;
        for (int k = 0; k < MAX_CHK; k++) begin
            if (CHK_W'(k) < r_s2_fmt.chk) begin
                n_s3_code[(1 << k) - 1] = ^r_s2_part[k];
            end
        end
    end

    assign o_done     = r_s3_vld;
    assign o_codeword = r_s3_code;
    assign o_fmt      = r_s3_fmt;

endmodule
